### rtl/seit_pkg.sv
// package for the sorted extent interval table
// request codes, widths, state codes and the response struct; no dependencies
`default_nettype none
package seit_pkg;

  localparam int unsigned MaxExtents = 64;
  localparam int unsigned NumSlots   = 4;
  localparam int unsigned OffsetBits = 48;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned SlotW  = 2;
  localparam int unsigned FieldW = 48;
  localparam int unsigned CountW = 7;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR_ALL  = 3'd0,
    REQ_CLEAR_SLOT = 3'd1,
    REQ_LOAD       = 3'd2,
    REQ_COMMIT     = 3'd3,
    REQ_FIND       = 3'd4,
    REQ_NEXT       = 3'd5,
    REQ_RSVD6      = 3'd6,
    REQ_RSVD7      = 3'd7
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_FILT_RD,
    ST_FILT_CHK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RES_RD,
    ST_RES_CHK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [FieldW-1:0] extent_start;
    logic [FieldW-1:0] extent_length;
    logic [CountW-1:0] kept_count;
    logic              layout_present;
  } resp_t;

endpackage
`default_nettype wire

### rtl/seit_if.sv
// valid/ready channel interfaces for the extent table
// depends on seit_pkg
`default_nettype none
interface seit_req_if;
  logic                       valid;
  logic                       ready;
  logic [seit_pkg::ReqW-1:0]  req_type;
  logic [seit_pkg::SlotW-1:0] layout_slot;
  logic [seit_pkg::FieldW-1:0] byte_offset;
  logic [seit_pkg::FieldW-1:0] byte_length;
  modport source (output valid, req_type, layout_slot, byte_offset, byte_length,
                  input ready);
  modport sink   (input valid, req_type, layout_slot, byte_offset, byte_length,
                  output ready);
endinterface

interface seit_resp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [seit_pkg::FieldW-1:0] extent_start;
  logic [seit_pkg::FieldW-1:0] extent_length;
  logic [seit_pkg::CountW-1:0] kept_count;
  logic                        layout_present;
  modport source (output valid, ok, extent_start, extent_length, kept_count,
                  layout_present, input ready);
  modport sink   (input valid, ok, extent_start, extent_length, kept_count,
                  layout_present, output ready);
endinterface
`default_nettype wire

### rtl/sorted_extent_interval_table.sv
// sorted extent interval table
// request channel in, response channel out; one response per request word.
// loads append to a staging memory while it has room.
// commit runs an in-place insertion sort over staging memory. A filter pass
// follows over the staged extents, writing the slot region of the table
// memory.
// find and next start first load the bounds, then run a binary search over
// the slot's region, with up to seven probes at the full count of 64. A read
// of the result, a check and the response state follow.
// clears and loads go from idle straight to the response state.
// the response sits in an output register; the block takes a new request only
// once the pending response is taken, so a stalled receiver stalls the
// requester.
// reset empties staging and all slots (counts and presence flags live in
// flip-flops); memory contents are left as they are and are never used
// beyond a count. depends on seit_pkg, seit_if, seit_ram.
`default_nettype none
module sorted_extent_interval_table #(
  parameter int unsigned MAX_EXTENTS = seit_pkg::MaxExtents,
  parameter int unsigned NUM_SLOTS   = seit_pkg::NumSlots,
  parameter int unsigned OFFSET_BITS = seit_pkg::OffsetBits
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  seit_req_if.sink    req,
  seit_resp_if.source resp
);
  localparam int unsigned IdxW  = $clog2(MAX_EXTENTS);
  localparam int unsigned CntW  = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned SlW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned TDep  = NUM_SLOTS * MAX_EXTENTS;
  localparam int unsigned TAw   = $clog2(TDep);
  localparam int unsigned OW    = OFFSET_BITS;
  localparam int unsigned FW    = seit_pkg::FieldW;
  localparam int unsigned CW    = seit_pkg::CountW;

  typedef logic [OW-1:0]  ofs_t;
  typedef logic [CntW-1:0] cnt_t;

  seit_pkg::state_e state_q, state_d;

  // request registers
  seit_pkg::req_e      rq_type_q, rq_type_d;
  logic [seit_pkg::SlotW-1:0] rq_slot_q, rq_slot_d;
  ofs_t                rq_off_q, rq_off_d;

  cnt_t                stg_cnt_q, stg_cnt_d;
  cnt_t                tcnt_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tvalid_q;
  logic                tc_we;
  cnt_t                tc_val;
  logic                clr_all, clr_one;

  // sort / filter / search working registers
  cnt_t  i_q, i_d, j_q, j_d;
  ofs_t  ks_q, ks_d, kl_q, kl_d;
  cnt_t  kept_q, kept_d;
  logic [OW:0] last_end_q, last_end_d;
  cnt_t  lo_q, lo_d, hi_q, hi_d;

  seit_pkg::resp_t rsp_q, rsp_d;
  logic  rvalid_q, rvalid_d;

  // staging memory
  logic              s_we;
  logic [IdxW-1:0]   s_wa, s_ra;
  logic [2*OW-1:0]   s_wd, s_rd;
  // table memory
  logic              t_we;
  logic [TAw-1:0]    t_wa, t_ra;
  logic [2*OW-1:0]   t_wd, t_rd;

  seit_ram #(.Depth(MAX_EXTENTS), .Width(2*OW)) u_stg (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );
  seit_ram #(.Depth(TDep), .Width(2*OW)) u_tbl (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );

  logic slot_in;
  logic [SlW-1:0] sl;
  ofs_t s_rs, s_rl, t_rs, t_rl;
  cnt_t slot_cnt, mid;
  logic slot_vld;
  logic [OW:0] t_end;
  logic req_free, req_acc;

  always_comb begin
    slot_in  = 32'(rq_slot_q) < NUM_SLOTS;
    sl       = SlW'(rq_slot_q);
    slot_cnt = slot_in ? tcnt_q[sl] : '0;
    slot_vld = slot_in & tvalid_q[sl];
    s_rs     = s_rd[2*OW-1:OW];
    s_rl     = s_rd[OW-1:0];
    t_rs     = t_rd[2*OW-1:OW];
    t_rl     = t_rd[OW-1:0];
    t_end    = {1'b0, t_rs} + {1'b0, t_rl};
    mid      = lo_q + ((hi_q - lo_q) >> 1);
    // output register is free once its word is gone or leaves this cycle
    req_free = !rvalid_q || resp.ready;
    req_acc  = (state_q == seit_pkg::ST_IDLE) && req.valid && req_free;
  end

  function automatic logic [TAw-1:0] taddr(logic [SlW-1:0] s, cnt_t k);
    logic [TAw+CntW-1:0] a;
    a = (TAw+CntW)'(s) * (TAw+CntW)'(MAX_EXTENTS) + (TAw+CntW)'(k);
    return a[TAw-1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      seit_pkg::ST_IDLE: begin
        if (req_acc) begin
          if (seit_pkg::req_e'(req.req_type) == seit_pkg::REQ_COMMIT) begin
            state_d = seit_pkg::ST_SORT_RD;
          end else if (seit_pkg::req_e'(req.req_type) inside
                       {seit_pkg::REQ_FIND, seit_pkg::REQ_NEXT}) begin
            state_d = seit_pkg::ST_SRCH_RD;
          end else begin
            state_d = seit_pkg::ST_RESP;
          end
        end
      end
      seit_pkg::ST_SORT_RD: begin
        if (!slot_in) state_d = seit_pkg::ST_RESP;
        else if (i_q >= stg_cnt_q) state_d = seit_pkg::ST_FILT_RD;
        else state_d = seit_pkg::ST_SORT_CMP;
      end
      seit_pkg::ST_SORT_CMP: state_d = seit_pkg::ST_SORT_WR;
      seit_pkg::ST_SORT_WR: begin
        if (j_q == '0 || s_rs <= ks_q) state_d = seit_pkg::ST_SORT_RD;
        else state_d = seit_pkg::ST_SORT_CMP;
      end
      seit_pkg::ST_FILT_RD: begin
        if (i_q >= stg_cnt_q) state_d = seit_pkg::ST_RESP;
        else state_d = seit_pkg::ST_FILT_CHK;
      end
      seit_pkg::ST_FILT_CHK: state_d = seit_pkg::ST_FILT_RD;
      seit_pkg::ST_SRCH_RD: begin
        // first visit only loads the upper bound
        if (i_q == '0) state_d = seit_pkg::ST_SRCH_RD;
        else if (lo_q < hi_q) state_d = seit_pkg::ST_SRCH_CMP;
        else state_d = seit_pkg::ST_RES_RD;
      end
      seit_pkg::ST_SRCH_CMP: state_d = seit_pkg::ST_SRCH_RD;
      seit_pkg::ST_RES_RD: state_d = seit_pkg::ST_RES_CHK;
      seit_pkg::ST_RES_CHK: state_d = seit_pkg::ST_RESP;
      seit_pkg::ST_RESP: if (!rvalid_q || resp.ready) state_d = seit_pkg::ST_IDLE;
      default: state_d = seit_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rq_type_d  = rq_type_q;
    rq_slot_d  = rq_slot_q;
    rq_off_d   = rq_off_q;
    stg_cnt_d  = stg_cnt_q;
    i_d = i_q; j_d = j_q; ks_d = ks_q; kl_d = kl_q;
    kept_d = kept_q; last_end_d = last_end_q; lo_d = lo_q; hi_d = hi_q;
    rsp_d = rsp_q;
    rvalid_d = rvalid_q;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    tc_we = 1'b0; tc_val = '0; clr_all = 1'b0; clr_one = 1'b0;
    req.ready = 1'b0;
    if (rvalid_q && resp.ready) rvalid_d = 1'b0;

    case (state_q)
      seit_pkg::ST_IDLE: begin
        req.ready = req_free;
        if (req_acc) begin
          rq_type_d = seit_pkg::req_e'(req.req_type);
          rq_slot_d = req.layout_slot;
          rq_off_d  = OW'(req.byte_offset);
          rsp_d     = '0;
          i_d = '0; kept_d = '0; last_end_d = '0; lo_d = '0;
          if (seit_pkg::req_e'(req.req_type) == seit_pkg::REQ_LOAD &&
              stg_cnt_q < cnt_t'(MAX_EXTENTS)) begin
            s_we = 1'b1;
            s_wa = IdxW'(stg_cnt_q);
            s_wd = {OW'(req.byte_offset), OW'(req.byte_length)};
            stg_cnt_d = stg_cnt_q + 1'b1;
            rsp_d.ok = 1'b1;
          end
        end
      end
      seit_pkg::ST_SORT_RD: begin
        // fetch element i as the key for insertion
        s_ra = IdxW'(i_q);
        j_d  = i_q;
        // sort done, filter restarts from the first element
        if (slot_in && i_q >= stg_cnt_q) i_d = '0;
      end
      seit_pkg::ST_SORT_CMP: begin
        if (j_q == i_q) begin
          ks_d = s_rs;
          kl_d = s_rl;
        end
        s_ra = IdxW'(j_q - 1'b1);
      end
      seit_pkg::ST_SORT_WR: begin
        s_we = 1'b1;
        if (j_q == '0 || s_rs <= ks_q) begin
          s_wa = IdxW'(j_q);
          s_wd = {ks_q, kl_q};
          i_d  = i_q + 1'b1;
        end else begin
          s_wa = IdxW'(j_q);
          s_wd = s_rd;
          j_d  = j_q - 1'b1;
        end
      end
      seit_pkg::ST_FILT_RD: begin
        s_ra = IdxW'(i_q);
        if (i_q >= stg_cnt_q) begin
          tc_we = 1'b1;
          tc_val = kept_q;
          stg_cnt_d = '0;
          rsp_d.ok = 1'b1;
          rsp_d.kept_count = CW'(kept_q);
          rsp_d.layout_present = 1'b1;
        end
      end
      seit_pkg::ST_FILT_CHK: begin
        i_d = i_q + 1'b1;
        if (s_rl != '0 && (kept_q == '0 || {1'b0, s_rs} >= last_end_q)) begin
          t_we = 1'b1;
          t_wa = taddr(sl, kept_q);
          t_wd = s_rd;
          kept_d = kept_q + 1'b1;
          last_end_d = {1'b0, s_rs} + {1'b0, s_rl};
        end
      end
      seit_pkg::ST_SRCH_RD: begin
        if (i_q == '0) begin
          hi_d = slot_vld ? slot_cnt : '0;
          i_d  = cnt_t'(1);
          t_ra = taddr(sl, mid);
        end else begin
          t_ra = taddr(sl, mid);
        end
      end
      seit_pkg::ST_SRCH_CMP: begin
        if (rq_type_q == seit_pkg::REQ_FIND ? (t_rs <= rq_off_q) : (t_rs < rq_off_q))
          lo_d = mid + 1'b1;
        else
          hi_d = mid;
      end
      seit_pkg::ST_RES_RD: begin
        t_ra = taddr(sl, (rq_type_q == seit_pkg::REQ_FIND) ? lo_q - 1'b1 : lo_q);
      end
      seit_pkg::ST_RES_CHK: begin
        rsp_d.kept_count = CW'(slot_cnt);
        rsp_d.layout_present = slot_vld;
        if (slot_vld) begin
          if (rq_type_q == seit_pkg::REQ_FIND) begin
            if (lo_q != '0 && {1'b0, rq_off_q} < t_end) begin
              rsp_d.ok = 1'b1;
              rsp_d.extent_start = FW'(t_rs);
              rsp_d.extent_length = FW'(t_rl);
            end
          end else if (lo_q < slot_cnt) begin
            rsp_d.ok = 1'b1;
            rsp_d.extent_start = FW'(t_rs);
          end
        end
      end
      seit_pkg::ST_RESP: begin
        if (state_d == seit_pkg::ST_IDLE) begin
          rvalid_d = 1'b1;
          case (rq_type_q)
            seit_pkg::REQ_CLEAR_ALL: begin
              clr_all = 1'b1;
              rsp_d.ok = 1'b1;
            end
            seit_pkg::REQ_CLEAR_SLOT: begin
              clr_one = slot_in;
              rsp_d.ok = 1'b1;
              rsp_d.kept_count = '0;
              rsp_d.layout_present = 1'b0;
            end
            seit_pkg::REQ_COMMIT: begin
              if (!slot_in) begin
                stg_cnt_d = '0;
                rsp_d.ok = 1'b0;
                rsp_d.kept_count = '0;
                rsp_d.layout_present = 1'b0;
              end
            end
            seit_pkg::REQ_FIND, seit_pkg::REQ_NEXT: ;
            default: begin
              rsp_d.kept_count = CW'(slot_cnt);
              rsp_d.layout_present = slot_vld;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= seit_pkg::ST_IDLE;
      stg_cnt_q <= '0;
      tvalid_q  <= '0;
      rvalid_q  <= 1'b0;
      i_q       <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) tcnt_q[k] <= '0;
    end else begin
      state_q   <= state_d;
      stg_cnt_q <= stg_cnt_d;
      rvalid_q  <= rvalid_d;
      i_q       <= i_d;
      if (clr_all) begin
        tvalid_q <= '0;
        for (int k = 0; k < NUM_SLOTS; k++) tcnt_q[k] <= '0;
      end else if (clr_one) begin
        tvalid_q[sl] <= 1'b0;
        tcnt_q[sl]   <= '0;
      end else if (tc_we) begin
        tvalid_q[sl] <= 1'b1;
        tcnt_q[sl]   <= tc_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rq_type_q  <= rq_type_d;
    rq_slot_q  <= rq_slot_d;
    rq_off_q   <= rq_off_d;
    j_q <= j_d; ks_q <= ks_d; kl_q <= kl_d;
    kept_q <= kept_d; last_end_q <= last_end_d; lo_q <= lo_d; hi_q <= hi_d;
    rsp_q <= rsp_d;
  end

  assign resp.valid          = rvalid_q;
  assign resp.ok             = rsp_q.ok;
  assign resp.extent_start   = rsp_q.extent_start;
  assign resp.extent_length  = rsp_q.extent_length;
  assign resp.kept_count     = rsp_q.kept_count;
  assign resp.layout_present = rsp_q.layout_present;
endmodule
`default_nettype wire

### rtl/seit_ram.sv
// simple dual port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none
module seit_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 96
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/seit_checker.sv
// port-level checker for the extent table, bound to the top level
// depends on seit_pkg and the channel interfaces
`default_nettype none
module seit_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        resp_valid,
  input wire logic                        resp_ready,
  input wire logic                        resp_ok,
  input wire logic [seit_pkg::FieldW-1:0] resp_len,
  input wire logic [seit_pkg::CountW-1:0] resp_cnt
);
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && !resp_ready |-> !req_ready) else $error("request taken while pending");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_len))
    else $error("response dropped");
  a_len_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && resp_len != '0 |-> resp_ok) else $error("length without hit");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid |-> resp_cnt <= seit_pkg::CountW'(seit_pkg::MaxExtents))
    else $error("count out of range");
  a_one_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !resp_valid || resp_ready || !req_ready)
    else $error("accept overlap");
endmodule

bind sorted_extent_interval_table seit_checker u_seit_checker (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .resp_valid(resp.valid), .resp_ready(resp.ready),
  .resp_ok(resp.ok), .resp_len(resp.extent_length), .resp_cnt(resp.kept_count)
);
`default_nettype wire

### sim/sorted_extent_interval_table_chk.sv
// checker for the sorted extent interval table: watches both channels,
// predicts each response from its own table copy and compares field by field
// depends on seit_pkg and seit_if
`timescale 1ns / 1ps
module sorted_extent_interval_table_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  seit_req_if.sink    req,
  seit_resp_if.sink   resp,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned resp_cnt_o
);
  typedef logic [seit_pkg::FieldW-1:0] ofs_t;
  typedef logic [seit_pkg::CountW-1:0] cnt_t;

  ofs_t            stg_start [seit_pkg::MaxExtents];
  ofs_t            stg_len   [seit_pkg::MaxExtents];
  int unsigned     stg_cnt;
  ofs_t            tbl_start [seit_pkg::NumSlots][seit_pkg::MaxExtents];
  ofs_t            tbl_len   [seit_pkg::NumSlots][seit_pkg::MaxExtents];
  int unsigned     tbl_cnt   [seit_pkg::NumSlots];
  bit              present   [seit_pkg::NumSlots];
  seit_pkg::resp_t expected_resp_q [$];
  int unsigned     fail_cnt;
  int unsigned     resp_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_resp_q.size();
  assign resp_cnt_o = resp_cnt;

  // stable sort of staging, then drop empty and overlapping extents
  function automatic int unsigned commit_layout(int unsigned s);
    ofs_t        ss [seit_pkg::MaxExtents];
    ofs_t        sl [seit_pkg::MaxExtents];
    int unsigned j, kept;
    logic [seit_pkg::FieldW:0] last_end;
    kept = 0;
    last_end = '0;
    for (int unsigned i = 0; i < stg_cnt; i++) begin
      j = i;
      while (j > 0 && ss[j-1] > stg_start[i]) begin
        ss[j] = ss[j-1];
        sl[j] = sl[j-1];
        j--;
      end
      ss[j] = stg_start[i];
      sl[j] = stg_len[i];
    end
    for (int unsigned i = 0; i < stg_cnt; i++) begin
      if (sl[i] == '0) continue;
      if (kept > 0 && {1'b0, ss[i]} < last_end) continue;
      tbl_start[s][kept] = ss[i];
      tbl_len[s][kept]   = sl[i];
      last_end = {1'b0, ss[i]} + {1'b0, sl[i]};
      kept++;
    end
    tbl_cnt[s] = kept;
    present[s] = 1'b1;
    return kept;
  endfunction

  function automatic seit_pkg::resp_t predict_lookup(seit_pkg::req_e op, int unsigned s,
                                                     ofs_t off, ofs_t len);
    seit_pkg::resp_t r;
    int unsigned p;
    r = '0;
    case (op)
      seit_pkg::REQ_CLEAR_ALL: begin
        for (int i = 0; i < seit_pkg::NumSlots; i++) begin
          present[i] = 1'b0;
          tbl_cnt[i] = 0;
        end
        r.ok = 1'b1;
      end
      seit_pkg::REQ_CLEAR_SLOT: begin
        present[s] = 1'b0;
        tbl_cnt[s] = 0;
        r.ok = 1'b1;
      end
      seit_pkg::REQ_LOAD: begin
        if (stg_cnt < seit_pkg::MaxExtents) begin
          stg_start[stg_cnt] = off;
          stg_len[stg_cnt]   = len;
          stg_cnt++;
          r.ok = 1'b1;
        end
      end
      seit_pkg::REQ_COMMIT: begin
        r.kept_count = cnt_t'(commit_layout(s));
        r.ok = 1'b1;
        stg_cnt = 0;
      end
      seit_pkg::REQ_FIND: begin
        if (present[s]) begin
          p = 0;
          while (p < tbl_cnt[s] && tbl_start[s][p] <= off) p++;
          if (p > 0 && {1'b0, off} <
              {1'b0, tbl_start[s][p-1]} + {1'b0, tbl_len[s][p-1]}) begin
            r.ok = 1'b1;
            r.extent_start  = tbl_start[s][p-1];
            r.extent_length = tbl_len[s][p-1];
          end
        end
      end
      seit_pkg::REQ_NEXT: begin
        if (present[s]) begin
          p = 0;
          while (p < tbl_cnt[s] && tbl_start[s][p] < off) p++;
          if (p < tbl_cnt[s]) begin
            r.ok = 1'b1;
            r.extent_start = tbl_start[s][p];
          end
        end
      end
      default: ;
    endcase
    if (op != seit_pkg::REQ_COMMIT) r.kept_count = cnt_t'(tbl_cnt[s]);
    r.layout_present = present[s];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    seit_pkg::resp_t got, want;
    if (!rst_ni) begin
      stg_cnt = 0;
      for (int i = 0; i < seit_pkg::NumSlots; i++) begin
        tbl_cnt[i] = 0;
        present[i] = 1'b0;
      end
      expected_resp_q.delete();
      fail_cnt = 0;
      resp_cnt = 0;
    end else begin
      if (resp.valid && resp.ready) begin
        got = '{resp.ok, resp.extent_start, resp.extent_length, resp.kept_count,
                resp.layout_present};
        resp_cnt++;
        if (expected_resp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected response word %p", got);
        end else begin
          want = expected_resp_q.pop_front();
          if (got.ok !== want.ok || got.extent_start !== want.extent_start ||
              got.extent_length !== want.extent_length ||
              got.kept_count !== want.kept_count ||
              got.layout_present !== want.layout_present) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
          end
        end
      end
      if (req.valid && req.ready)
        expected_resp_q = {expected_resp_q,
                           predict_lookup(seit_pkg::req_e'(req.req_type), req.layout_slot,
                                          req.byte_offset, req.byte_length)};
    end
  end
endmodule

### sim/sorted_extent_interval_table_tb.sv
// stimulus and verdict for the sorted extent interval table
// depends on seit_pkg, seit_if, the block and sorted_extent_interval_table_chk
`timescale 1ns / 1ps
module sorted_extent_interval_table_tb;
  typedef logic [seit_pkg::FieldW-1:0] ofs_t;
  typedef logic [seit_pkg::SlotW-1:0]  slot_t;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_cnt, pending, resp_cnt;
  int unsigned sent;
  bit          no_idle;
  bit          hold_off;
  bit          held;

  seit_req_if  req ();
  seit_resp_if resp ();

  sorted_extent_interval_table uut (.clk_i, .rst_ni, .req, .resp);
  sorted_extent_interval_table_chk chk (.clk_i, .rst_ni, .req, .resp,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .resp_cnt_o(resp_cnt));

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("sorted_extent_interval_table_tb failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    resp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        resp.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      resp.ready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  function automatic ofs_t rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // one request word; random gap before it unless idling is off
  task automatic send_word(seit_pkg::req_e op, slot_t s, ofs_t off, ofs_t len);
    while (!no_idle && $urandom_range(99) < 24) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.req_type    <= op;
    req.layout_slot <= s;
    req.byte_offset <= off;
    req.byte_length <= len;
    do @(posedge clk_i); while (!req.ready);
    sent++;
  endtask

  // mostly small clustered extents so finds and next-start land on them
  task automatic load_layout(slot_t s, int unsigned n);
    ofs_t base;
    base = ($urandom_range(3) == 0) ? rand48() : ofs_t'($urandom_range(4000));
    for (int unsigned i = 0; i < n; i++)
      send_word(seit_pkg::REQ_LOAD, s, base + ofs_t'($urandom_range(2000)),
                ($urandom_range(9) == 0) ? '0 :
                ($urandom_range(19) == 0) ? rand48() : ofs_t'($urandom_range(300)));
  endtask

  initial begin
    seit_pkg::req_e op;
    slot_t s;
    int cyc;
    req.valid = 1'b0;
    req.req_type = '0;
    req.layout_slot = '0;
    req.byte_offset = '0;
    req.byte_length = '0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    held = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: queries with no layout, empty commit, ties, overlaps, extremes
    send_word(seit_pkg::REQ_FIND, 2'd0, '0, '0);
    send_word(seit_pkg::REQ_NEXT, 2'd1, '1, '0);
    send_word(seit_pkg::REQ_COMMIT, 2'd1, '0, '0);
    send_word(seit_pkg::REQ_NEXT, 2'd1, '0, '0);
    send_word(seit_pkg::REQ_LOAD, 2'd0, 48'd100, 48'd50);
    send_word(seit_pkg::REQ_LOAD, 2'd0, 48'd100, 48'd10);
    send_word(seit_pkg::REQ_LOAD, 2'd0, 48'd20, 48'd0);
    send_word(seit_pkg::REQ_LOAD, 2'd0, 48'd120, 48'd5);
    send_word(seit_pkg::REQ_LOAD, 2'd0, 48'd150, 48'd1);
    send_word(seit_pkg::REQ_LOAD, 2'd0, '1, '1);
    send_word(seit_pkg::REQ_COMMIT, 2'd0, '0, '0);
    send_word(seit_pkg::REQ_FIND, 2'd0, 48'd149, '1);
    send_word(seit_pkg::REQ_FIND, 2'd0, 48'd150, '0);
    send_word(seit_pkg::REQ_FIND, 2'd0, 48'd151, '0);
    send_word(seit_pkg::REQ_FIND, 2'd0, '1, '0);
    send_word(seit_pkg::REQ_NEXT, 2'd0, 48'd101, '0);
    send_word(seit_pkg::REQ_NEXT, 2'd0, '1, '0);
    send_word(seit_pkg::REQ_RSVD6, 2'd0, '0, '0);
    send_word(seit_pkg::REQ_RSVD7, 2'd3, '1, '1);
    send_word(seit_pkg::REQ_CLEAR_SLOT, 2'd0, '0, '0);
    send_word(seit_pkg::REQ_FIND, 2'd0, 48'd100, '0);
    // fill staging past full
    for (int i = 0; i < seit_pkg::MaxExtents + 2; i++)
      send_word(seit_pkg::REQ_LOAD, 2'd3, ofs_t'(i * 7), 48'd3);
    send_word(seit_pkg::REQ_COMMIT, 2'd3, '0, '0);
    send_word(seit_pkg::REQ_CLEAR_ALL, 2'd2, '0, '0);

    while (sent < 1250) begin
      if (sent > 500 && sent < 700) no_idle = 1'b1;
      else no_idle = 1'b0;
      if (sent > 900 && !held) begin
        hold_off = 1'b1;
        held = 1'b1;
      end
      s = slot_t'($urandom);
      if ($urandom_range(9) < 8) begin
        load_layout(s, $urandom_range(15) == 0 ? seit_pkg::MaxExtents + 1
                                                : $urandom_range(12));
        send_word(seit_pkg::REQ_COMMIT, s, rand48(), rand48());
        repeat ($urandom_range(8)) begin
          op = ($urandom_range(1) == 0) ? seit_pkg::REQ_FIND : seit_pkg::REQ_NEXT;
          send_word(op, ($urandom_range(4) == 0) ? slot_t'($urandom) : s,
                    ($urandom_range(4) == 0) ? rand48() : ofs_t'($urandom_range(6500)),
                    rand48());
        end
      end else begin
        op = seit_pkg::req_e'($urandom_range(7));
        send_word(op, s, rand48(), rand48());
      end
    end
    req.valid <= 1'b0;

    cyc = 0;
    while (pending != 0 && cyc < 200000) begin
      @(posedge clk_i);
      cyc++;
    end
    repeat (50) @(posedge clk_i);
    $display("sent %0d request words, checked %0d responses over four slots", sent, resp_cnt);
    $display("covered loads to overflow, stable ties, overlap drops, find and next start");
    if (pending == 0 && fail_cnt == 0) begin
      $display("sorted_extent_interval_table_tb passed");
    end else begin
      $display("sorted_extent_interval_table_tb failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/seit_pkg.sv
rtl/seit_if.sv
rtl/seit_ram.sv
rtl/sorted_extent_interval_table.sv
rtl/seit_checker.sv
sim/sorted_extent_interval_table_chk.sv
sim/sorted_extent_interval_table_tb.sv
